// File: rtl/core/apl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apl_pkg: shared definitions for the permuted line address generator
// Widths, register indexes, status codes and the cell control and token types.
// ----------------------------------------------------------------------------
package apl_pkg;

	// number of axes the cell row supports
	localparam int MAX_AXES = 4;
	localparam int AXIS_W   = $clog2(MAX_AXES);

	localparam int SIZE_W    = 16;
	localparam int LINE_W    = 32;
	localparam int BYTES_W   = 36;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE3      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ORDER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 3'd6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd2;

	// per-cell control from the sequencer
	typedef struct packed {
		logic              clear;
		logic              cfg_load;
		logic              en;
		logic [SIZE_W-1:0] extm1;
		logic              stride_wr;
		logic [LINE_W-1:0] stride;
	} cell_ctl_t;

	// token handed from cell to cell: increment carry and running line index
	typedef struct packed {
		logic              valid;
		logic              carry;
		logic [LINE_W-1:0] sum;
	} tok_t;

endpackage
`default_nettype wire

// File: rtl/core/apl_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apl_ifs: request and response channels of the line address generator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface apl_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface apl_out_if;
	logic                          valid;
	logic                          ready;
	logic [apl_pkg::STATUS_W-1:0]  status;
	logic [apl_pkg::LINE_W-1:0]    source_line;
	logic [apl_pkg::LINE_W-1:0]    dest_line;
	logic [apl_pkg::BYTES_W-1:0]   line_bytes;
	logic                          last_line;

	modport source (output valid, output status, output source_line, output dest_line,
		output line_bytes, output last_line, input ready);
	modport sink (input valid, input status, input source_line, input dest_line,
		input line_bytes, input last_line, output ready);
endinterface
`default_nettype wire

// File: rtl/core/apl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apl_cell: one input axis of the coordinate counter
// Holds the axis coordinate and its weighted share of the destination line,
// adds that share to the passing token and advances on an incoming carry.
// ----------------------------------------------------------------------------
module apl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  apl_pkg::cell_ctl_t ctl,
	input  apl_pkg::tok_t      tok_in,
	output apl_pkg::tok_t      tok_out
);
	import apl_pkg::*;

	logic [SIZE_W-1:0] coord_q;
	logic [SIZE_W-1:0] extm1_q;
	logic [LINE_W-1:0] stride_q;
	logic [LINE_W-1:0] partial_q;
	logic              en_q;
	logic              tok_valid_q;
	logic              tok_carry_q;
	logic [LINE_W-1:0] tok_sum_q;
	logic              step;
	logic              wrap;

	assign step = tok_in.valid && en_q && tok_in.carry;
	assign wrap = (coord_q == extm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			extm1_q     <= '0;
			coord_q     <= '0;
			partial_q   <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
			if (ctl.cfg_load) begin
				en_q    <= ctl.en;
				extm1_q <= ctl.extm1;
			end
			if (ctl.clear) begin
				coord_q   <= '0;
				partial_q <= '0;
			end else if (step) begin
				if (wrap) begin
					coord_q   <= '0;
					partial_q <= '0;
				end else begin
					coord_q   <= coord_q + 16'd1;
					partial_q <= partial_q + stride_q;
				end
			end
		end
	end

	// pass the token on; the share added is the one before this step
	always_ff @(posedge clk) begin
		if (ctl.stride_wr) begin
			stride_q <= ctl.stride;
		end
		tok_carry_q <= en_q ? (tok_in.carry && wrap) : tok_in.carry;
		tok_sum_q   <= en_q ? (tok_in.sum + partial_q) : tok_in.sum;
	end

	assign tok_out.valid = tok_valid_q;
	assign tok_out.carry = tok_carry_q;
	assign tok_out.sum   = tok_sum_q;

endmodule
`default_nettype wire

// File: rtl/core/axis_permute_line_address_gen_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// axis_permute_line_address_gen_core: line addresses for an axis-permuting copy
// Checks and prepares the axis order on a restart item, then yields one line
// copy (source line, destination line, bytes, last flag) per advance item.
// ----------------------------------------------------------------------------
//
//  channel  role     payload                                        handshake
//  -------  -------  ---------------------------------------------  -----------
//  req      sink     restart                                        valid/ready
//  rsp      source   status, source_line, dest_line, line_bytes,    valid/ready
//                    last_line
//  cfg      write    cfg_index, cfg_data                            cfg_wr_en
//
//  Steps: a line advance walks a token down the cell row, one cell per cycle;
//  a restart runs one multiply step per axis, then the byte count; rejected
//  items and whole-array lines go from S_IDLE straight to S_DONE.
//  Reset clears the pass, so advances report a bad order until a restart.
//  req is taken whenever the sequencer is idle, also while a result waits in
//  the rsp register; a stalled rsp holds the sequencer in its final state.
//
module axis_permute_line_address_gen_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [apl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apl_pkg::CFG_DAT_W-1:0]   cfg_data,
	apl_in_if.sink                          req,
	apl_out_if.source                       rsp
);
	import apl_pkg::*;

	localparam logic [AXIS_W-1:0] K_LAST     = AXIS_W'(MAX_AXES - 1);
	localparam logic [48:0]       TWO_POW_32 = 49'h1_0000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_BYTES,
		S_WALK,
		S_DONE
	} state_t;

	// extent of an axis: a zero size counts as one
	function automatic logic [SIZE_W-1:0] ext_of(input logic [SIZE_W-1:0] s);
		return (s == '0) ? 16'd1 : s;
	endfunction

	// input axis placed at output axis j
	function automatic logic [1:0] field_of(input logic [7:0] ord, input logic [1:0] j);
		return ord[2*j +: 2];
	endfunction

	// configuration registers
	logic [2:0]        axis_count_q;
	logic [SIZE_W-1:0] size_q [4];
	logic [7:0]        order_q;
	logic [3:0]        eb_q;

	// pass state
	state_t             state_q;
	logic               order_valid_q;
	logic [2:0]         fixed_q;
	logic [LINE_W-1:0]  counter_q;
	logic [32:0]        lines_q;
	logic [32:0]        total_q;
	logic [32:0]        p0f_q;
	logic               ovf_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [AXIS_W-1:0]  k_q;

	// staged result
	logic [STATUS_W-1:0] res_status_q;
	logic [LINE_W-1:0]   res_src_q;
	logic [LINE_W-1:0]   res_dst_q;
	logic [BYTES_W-1:0]  res_bytes_q;
	logic                res_last_q;

	// response register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [LINE_W-1:0]   rsp_src_q;
	logic [LINE_W-1:0]   rsp_dst_q;
	logic [BYTES_W-1:0]  rsp_bytes_q;
	logic                rsp_last_q;

	logic        acc;
	logic        acc_restart;
	logic        launch;
	logic        cfg_hit;
	logic        rsp_free;
	logic        ok_c;
	logic [2:0]  f_c;
	logic [2:0]  n;
	logic [1:0]  fld_k;
	logic        mul_act;
	logic        str_act;
	logic [48:0] prod1;
	logic [48:0] prod2;
	logic [32:0] base;
	logic [36:0] bytes_full;
	logic [32:0] cnt_next;
	logic        last_c;

	cell_ctl_t cell_ctl  [MAX_AXES];
	tok_t      tok_chain [MAX_AXES+1];

	assign n           = axis_count_q;
	assign req.ready   = (state_q == S_IDLE);
	assign acc         = req.valid && req.ready;
	assign acc_restart = acc && req.restart;
	assign cfg_hit     = cfg_wr_en && (cfg_index <= CFG_ELEM_BYTES);
	assign rsp_free    = !rsp_valid_q || rsp.ready;

	// check the order: every used field in range and named once; count the
	// leading output axes that keep their own input axis
	always_comb begin
		logic [3:0] used;
		logic [1:0] v;
		logic       run;
		ok_c = (n >= 3'd1) && (n <= 3'(MAX_AXES));
		used = '0;
		f_c  = '0;
		run  = 1'b1;
		for (int j = 0; j < 4; j++) begin
			v = field_of(order_q, 2'(j));
			if (3'(j) < n) begin
				if (({1'b0, v} >= n) || used[v]) begin
					ok_c = 1'b0;
				end
				used[v] = 1'b1;
				if (run && (v == 2'(j))) begin
					f_c = 3'(j + 1);
				end else begin
					run = 1'b0;
				end
			end
		end
	end

	// setup datapath: element count over input axes, destination strides over
	// the moving output axes, bytes per line
	always_comb begin
		fld_k      = field_of(order_q, 2'(k_q));
		mul_act    = (3'(k_q) < n);
		str_act    = (3'(k_q) >= fixed_q) && (3'(k_q) < n);
		prod1      = total_q * ext_of(size_q[2'(k_q)]);
		prod2      = lines_q * ext_of(size_q[fld_k]);
		base       = (fixed_q >= n) ? total_q : p0f_q;
		bytes_full = base * eb_q;
		cnt_next   = {1'b0, counter_q} + 33'd1;
		last_c     = (cnt_next >= lines_q);
	end

	// cell control: clear and arm on restart, load strides during setup
	always_comb begin
		for (int d = 0; d < MAX_AXES; d++) begin
			cell_ctl[d].clear     = acc_restart;
			cell_ctl[d].cfg_load  = acc_restart;
			cell_ctl[d].en        = (3'(d) >= f_c) && (3'(d) < n);
			cell_ctl[d].extm1     = ext_of(size_q[2'(d)]) - 16'd1;
			cell_ctl[d].stride_wr = (state_q == S_SETUP) && str_act && (fld_k == 2'(d));
			cell_ctl[d].stride    = lines_q[LINE_W-1:0];
		end
	end

	// launch one token per line: carry in at the lowest axis, empty sum
	assign launch = acc && !req.restart && order_valid_q && (fixed_q < n);

	assign tok_chain[0].valid = launch;
	assign tok_chain[0].carry = 1'b1;
	assign tok_chain[0].sum   = '0;

	for (genvar d = 0; d < MAX_AXES; d++) begin : g_cell
		apl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl[d]),
			.tok_in  (tok_chain[d]),
			.tok_out (tok_chain[d+1])
		);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q <= 3'd1;
			size_q       <= '{default: 16'd1};
			order_q      <= 8'd228;
			eb_q         <= 4'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_AXIS_COUNT: axis_count_q <= cfg_data[2:0];
				CFG_SIZE0:      size_q[0]    <= cfg_data;
				CFG_SIZE1:      size_q[1]    <= cfg_data;
				CFG_SIZE2:      size_q[2]    <= cfg_data;
				CFG_SIZE3:      size_q[3]    <= cfg_data;
				CFG_AXIS_ORDER: order_q      <= cfg_data[7:0];
				CFG_ELEM_BYTES: eb_q         <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer, pass state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			order_valid_q <= 1'b0;
			fixed_q       <= '0;
			counter_q     <= '0;
			lines_q       <= 33'd1;
			total_q       <= 33'd1;
			p0f_q         <= 33'd1;
			ovf_q         <= 1'b0;
			bytes_q       <= '0;
			k_q           <= '0;
			res_status_q  <= ST_OK;
			res_src_q     <= '0;
			res_dst_q     <= '0;
			res_bytes_q   <= '0;
			res_last_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= ST_OK;
			rsp_src_q     <= '0;
			rsp_dst_q     <= '0;
			rsp_bytes_q   <= '0;
			rsp_last_q    <= 1'b0;
		end else begin
			// drop the response once taken; a new load below overrides
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_src_q   <= '0;
						res_dst_q   <= '0;
						res_bytes_q <= '0;
						res_last_q  <= 1'b0;
						if (req.restart) begin
							counter_q     <= '0;
							order_valid_q <= 1'b0;
							res_status_q  <= ST_OK;
							if (ok_c) begin
								fixed_q <= f_c;
								total_q <= 33'd1;
								lines_q <= 33'd1;
								p0f_q   <= 33'd1;
								ovf_q   <= 1'b0;
								k_q     <= '0;
								state_q <= S_SETUP;
							end else begin
								res_status_q <= ST_BAD_ORDER;
								state_q      <= S_DONE;
							end
						end else if (!order_valid_q) begin
							res_status_q <= ST_BAD_ORDER;
							state_q      <= S_DONE;
						end else if (fixed_q >= n) begin
							// identity order: the whole array is one line
							res_status_q <= ST_OK;
							res_bytes_q  <= bytes_q;
							res_last_q   <= 1'b1;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							res_src_q    <= counter_q;
							res_bytes_q  <= bytes_q;
							res_last_q   <= last_c;
							counter_q    <= last_c ? '0 : counter_q + 32'd1;
							state_q      <= S_WALK;
						end
					end
				end

				S_SETUP: begin
					if (mul_act) begin
						total_q <= prod1[32:0];
						if (prod1 > TWO_POW_32) begin
							ovf_q <= 1'b1;
						end
					end
					if (3'(k_q) == fixed_q) begin
						p0f_q <= total_q;
					end
					if (str_act) begin
						lines_q <= prod2[32:0];
					end
					if (k_q == K_LAST) begin
						state_q <= S_BYTES;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end

				S_BYTES: begin
					bytes_q       <= bytes_full[BYTES_W-1:0];
					res_status_q  <= ovf_q ? ST_TOO_BIG : ST_OK;
					order_valid_q <= !ovf_q;
					state_q       <= S_DONE;
				end

				S_WALK: begin
					// hold until the token leaves the last cell
					if (tok_chain[MAX_AXES].valid) begin
						if (rsp_free) begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= res_status_q;
							rsp_src_q    <= res_src_q;
							rsp_dst_q    <= tok_chain[MAX_AXES].sum;
							rsp_bytes_q  <= res_bytes_q;
							rsp_last_q   <= res_last_q;
							state_q      <= S_IDLE;
						end else begin
							res_dst_q <= tok_chain[MAX_AXES].sum;
							state_q   <= S_DONE;
						end
					end
				end

				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_src_q    <= res_src_q;
						rsp_dst_q    <= res_dst_q;
						rsp_bytes_q  <= res_bytes_q;
						rsp_last_q   <= res_last_q;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase

			// any listed register write ends the pass
			if (cfg_hit) begin
				order_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.source_line = rsp_src_q;
	assign rsp.dest_line   = rsp_dst_q;
	assign rsp.line_bytes  = rsp_bytes_q;
	assign rsp.last_line   = rsp_last_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the permuted line address generator
// Drives restart and advance items through the request channel, predicts every
// line copy in a cycle-free model of the address walk, and compares each
// result field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import apl_pkg::*;

	// register index with no register behind it; a write there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	// quiet cycles after the last result before a register write or the end
	localparam int SETTLE_CYCLES = MAX_AXES + 8;
	localparam int REPORT_LIMIT  = 100;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LINE_W-1:0]   source_line;
		logic [LINE_W-1:0]   dest_line;
		logic [BYTES_W-1:0]  line_bytes;
		logic                last_line;
	} line_copy_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	apl_in_if  req_ch ();
	apl_out_if rsp_ch ();

	axis_permute_line_address_gen_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// shadow registers, updated at the edge that writes the block's copy
	logic [2:0]  rg_axis_count;
	logic [15:0] rg_size [4];
	logic [7:0]  rg_order;
	logic [3:0]  rg_elem_bytes;

	// walk state of the address predictor
	logic [15:0] pm_coord [4];
	logic [1:0]  pm_inv [4];
	logic [31:0] pm_line;
	logic [2:0]  pm_fixed;
	bit          pm_valid;

	line_copy_t pending_lines [$];
	int         mismatch_count;
	int         rsp_hold_req;
	int         burst_left;
	bit         gaps_on;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// extent of input axis d; a zero size register counts as one
	function automatic logic [63:0] extent(input int d);
		return (rg_size[d & 3] == 16'd0) ? 64'd1 : 64'(rg_size[d & 3]);
	endfunction

	// input axis placed at output axis j
	function automatic logic [1:0] order_at(input int j);
		return rg_order[2 * (j & 3) +: 2];
	endfunction

	// product of input extents over axes [from, to)
	function automatic logic [63:0] extent_span(input int from, input int to);
		logic [63:0] p;
		p = 64'd1;
		for (int d = from; d < to && d < 4; d++)
			p = p * extent(d);
		return p;
	endfunction

	// Work out the line copy that one accepted item yields and advance the walk.
	function automatic line_copy_t predict_line_copy(input bit restart);
		line_copy_t  r;
		int          n;
		int          j;
		int          d;
		int          f;
		int          k;
		bit          ok;
		logic [3:0]  used;
		logic [63:0] lines;
		logic [63:0] acc;
		r = '0;
		n = rg_axis_count;
		if (restart) begin
			// check the order: every field in range and no axis named twice
			ok = (n >= 1 && n <= MAX_AXES);
			used = '0;
			if (ok) begin
				for (j = 0; j < n; j++) begin
					if (order_at(j) >= n || used[order_at(j)])
						ok = 1'b0;
					used[order_at(j)] = 1'b1;
				end
			end
			for (j = 0; j < 4; j++)
				pm_coord[j] = '0;
			pm_line = '0;
			pm_valid = 1'b0;
			if (!ok) begin
				r.status = ST_BAD_ORDER;
			end else begin
				for (j = 0; j < n; j++)
					pm_inv[order_at(j)] = 2'(j);
				// leading axes that stay in place form one contiguous line
				for (j = 0; j < n && order_at(j) == j; j++) begin
				end
				pm_fixed = 3'(j);
				if (extent_span(0, n) > 64'h1_0000_0000)
					r.status = ST_TOO_BIG;
				else
					pm_valid = 1'b1;
			end
		end else if (!pm_valid) begin
			r.status = ST_BAD_ORDER;
		end else if (pm_fixed >= n) begin
			// identity: the whole array is one line
			acc = extent_span(0, n) * rg_elem_bytes;
			r.line_bytes = acc[BYTES_W-1:0];
			r.last_line = 1'b1;
		end else begin
			f = pm_fixed;
			lines = extent_span(f, n);
			acc = extent_span(0, f) * rg_elem_bytes;
			r.line_bytes = acc[BYTES_W-1:0];
			r.source_line = pm_line;
			// fold output coordinates, outermost first, into the output line index
			acc = 64'(pm_coord[(n - 1) & 3]);
			for (d = n - 1; d > f; d--)
				acc = 64'(pm_coord[(d - 1) & 3]) + extent(order_at(d - 1)) * acc;
			r.dest_line = acc[LINE_W-1:0];
			r.last_line = (64'(pm_line) + 64'd1 >= lines);
			if (r.last_line) begin
				// wrap: the next advance starts the same pass again
				for (j = 0; j < 4; j++)
					pm_coord[j] = '0;
				pm_line = '0;
			end else begin
				// step in input order, carrying into the next input axis
				pm_line++;
				d = f;
				k = pm_inv[d & 3];
				pm_coord[k]++;
				while (d < n && 64'(pm_coord[k]) >= extent(d)) begin
					pm_coord[k] = '0;
					d++;
					if (d < n) begin
						k = pm_inv[d & 3];
						pm_coord[k]++;
					end
				end
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Shared drivers and checks
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Offer one item and hold it until the block takes it. Valid stays high on
	// return so a following item goes out back to back; a burst may end with a gap.
	task automatic send_req(input bit restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
			if (gaps_on && gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_lines.push_back(predict_line_copy(restart));
	endtask

	// Drop valid and wait for every expected line to come back.
	task automatic wait_results();
		req_ch.valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
	endtask

	// Make the block idle before touching a register.
	task automatic quiesce();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register. The enable stays high so writes go out back to back;
	// end_reg_writes lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_AXIS_COUNT: begin
				rg_axis_count = data[2:0];
				pm_valid = 1'b0;
			end
			CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3: begin
				rg_size[idx - CFG_SIZE0] = data;
				pm_valid = 1'b0;
			end
			CFG_AXIS_ORDER: begin
				rg_order = data[7:0];
				pm_valid = 1'b0;
			end
			CFG_ELEM_BYTES: begin
				rg_elem_bytes = data[3:0];
				pm_valid = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic end_reg_writes();
		cfg_wr_en <= 1'b0;
	endtask

	// Idle the block and load every register.
	task automatic configure(input logic [15:0] count, input logic [15:0] s0,
			input logic [15:0] s1, input logic [15:0] s2, input logic [15:0] s3,
			input logic [15:0] order, input logic [15:0] ebytes);
		quiesce();
		write_reg(CFG_AXIS_COUNT, count);
		write_reg(CFG_SIZE0, s0);
		write_reg(CFG_SIZE1, s1);
		write_reg(CFG_SIZE2, s2);
		write_reg(CFG_SIZE3, s3);
		write_reg(CFG_AXIS_ORDER, order);
		write_reg(CFG_ELEM_BYTES, ebytes);
		end_reg_writes();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Out of reset: no pass yet, then the reset registers give one 1-byte line.
	task automatic test_reset_defaults();
		send_req(1'b0);
		send_req(1'b1);
		send_req(1'b0);
	endtask

	// Axis counts out of range, a repeated axis, an axis beyond the count.
	task automatic test_order_checks();
		configure(16'h0008, 16'd1, 16'd1, 16'd1, 16'd1, 16'hE4, 16'd1);
		send_req(1'b1);
		configure(16'hFFFD, 16'd1, 16'd1, 16'd1, 16'd1, 16'hE4, 16'd1);
		send_req(1'b1);
		configure(16'h0007, 16'd1, 16'd1, 16'd1, 16'd1, 16'hE4, 16'd1);
		send_req(1'b1);
		configure(16'd2, 16'd4, 16'd4, 16'd1, 16'd1, 16'h00, 16'd1);
		send_req(1'b1);
		configure(16'd3, 16'd2, 16'd2, 16'd2, 16'd1, 16'h13, 16'd1);
		send_req(1'b1);
	endtask

	// Element count above 2^32, exactly 2^32 with the widest element, a zero
	// extent and a zero element size.
	task automatic test_size_extremes();
		configure(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hE4, 16'd8);
		send_req(1'b1);
		send_req(1'b0);
		configure(16'd4, 16'd256, 16'd256, 16'd256, 16'd256, 16'hE4, 16'hFFFF);
		send_req(1'b1);
		send_req(1'b0);
		configure(16'd3, 16'd0, 16'd2, 16'd0, 16'd0, 16'h06, 16'd0);
		send_req(1'b1);
		repeat (3) send_req(1'b0);
	endtask

	// Full walk of a 2x3 transpose and one step past the end of the pass.
	task automatic test_transpose_walk();
		configure(16'd2, 16'd2, 16'd3, 16'd5, 16'd7, 16'hB1, 16'd8);
		send_req(1'b1);
		repeat (7) send_req(1'b0);
	endtask

	// A write to a listed register ends the pass; the spare index does not.
	task automatic test_config_ends_pass();
		configure(16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'hE4, 16'd1);
		send_req(1'b1);
		send_req(1'b0);
		quiesce();
		write_reg(CFG_SPARE, 16'hFFFF);
		end_reg_writes();
		send_req(1'b0);
		quiesce();
		write_reg(CFG_ELEM_BYTES, 16'd2);
		end_reg_writes();
		send_req(1'b0);
	endtask

	// Hold the result channel off for a long stretch while items keep coming,
	// so the block fills up and stalls its request channel.
	task automatic test_backpressure();
		configure(16'd3, 16'd2, 16'd3, 16'd2, 16'd1, 16'h12, 16'd4);
		send_req(1'b1);
		rsp_hold_req = 300;
		gaps_on = 1'b0;
		repeat (40) send_req(1'b0);
		gaps_on = 1'b1;
		wait_results();
	endtask

	// Random phases: a random configuration, a restart, then mostly advances
	// that walk a pass past its end, with stray restarts as noise.
	task automatic test_random_passes(input int item_goal);
		int          sent;
		int          n;
		int          nn;
		int          j;
		int          k;
		int          t;
		int          adv;
		int          perm [4];
		logic [15:0] count_w;
		logic [15:0] size_w [4];
		logic [15:0] order_w;
		logic [15:0] eb_w;
		logic [63:0] lines;
		sent = 0;
		while (sent < item_goal) begin
			// axis count: mostly 2..4, sometimes 1, rarely out of range
			t = $urandom_range(0, 31);
			if (t == 0)
				n = 0;
			else if (t == 1)
				n = $urandom_range(5, 7);
			else if (t < 5)
				n = 1;
			else
				n = $urandom_range(2, 4);
			count_w = 16'(n);
			if ($urandom_range(0, 7) == 0)
				count_w[15:3] = 13'($urandom);
			// extents: mostly tiny so passes wrap, a few at the extremes
			for (j = 0; j < 4; j++) begin
				t = $urandom_range(0, 15);
				if (t == 0)
					size_w[j] = 16'd0;
				else if (t == 1)
					size_w[j] = 16'hFFFF;
				else if (t == 2)
					size_w[j] = 16'($urandom_range(1, 65535));
				else
					size_w[j] = 16'($urandom_range(1, 4));
			end
			// order: a shuffled permutation with random unused fields, or noise
			nn = (n >= 1 && n <= MAX_AXES) ? n : MAX_AXES;
			for (j = 0; j < 4; j++)
				perm[j] = j;
			for (j = nn - 1; j > 0; j--) begin
				k = $urandom_range(0, j);
				t = perm[j];
				perm[j] = perm[k];
				perm[k] = t;
			end
			order_w = 16'($urandom);
			if ($urandom_range(0, 9) != 0) begin
				for (j = 0; j < nn; j++)
					order_w[2 * j +: 2] = perm[j][1:0];
			end
			t = $urandom_range(0, 15);
			eb_w = (t == 0) ? 16'd0 : (t == 1) ? 16'($urandom_range(9, 15))
				: 16'($urandom_range(1, 8));
			if ($urandom_range(0, 7) == 0)
				eb_w[15:4] = 12'($urandom);
			configure(count_w, size_w[0], size_w[1], size_w[2], size_w[3], order_w, eb_w);

			send_req(1'b1);
			sent++;
			if (!pm_valid) begin
				adv = $urandom_range(0, 3);
			end else begin
				lines = (pm_fixed >= rg_axis_count) ? 64'd1
					: extent_span(pm_fixed, rg_axis_count);
				if (lines <= 40 && $urandom_range(0, 3) != 0)
					adv = int'(lines) * $urandom_range(1, 2) + $urandom_range(0, 2);
				else
					adv = $urandom_range(1, 30);
			end
			repeat (adv) begin
				send_req($urandom_range(0, 19) == 0);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and sequence
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_AXIS_COUNT;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.restart <= 1'b0;
		mismatch_count = 0;
		rsp_hold_req = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		// reset values of the registers and the walk
		rg_axis_count = 3'd1;
		rg_order = 8'hE4;
		rg_elem_bytes = 4'd1;
		pm_line = '0;
		pm_fixed = '0;
		pm_valid = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rg_size[i] = 16'd1;
			pm_coord[i] = '0;
			pm_inv[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_order_checks();
		test_size_extremes();
		test_transpose_walk();
		test_config_ends_pass();
		test_backpressure();
		test_random_passes(1250);

		// drain, then give the block time to show any stray result
		wait_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_lines.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Result channel ready: random styles over random stretches, and a long
	// hold-off whenever a test asks for one.
	initial begin : rsp_ready_gen
		int style;
		int stretch;
		int hold_left;
		int beat;
		style = 0;
		stretch = 0;
		hold_left = 0;
		beat = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req != 0) begin
				hold_left = rsp_hold_req;
				rsp_hold_req = 0;
			end
			if (stretch == 0) begin
				style = $urandom_range(0, 3);
				stretch = $urandom_range(8, 64);
			end
			stretch--;
			beat++;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (style)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (beat % 5) < 3;
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare every accepted result with the oldest expected line copy.
	initial begin : line_check
		line_copy_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_lines.size() == 0) begin
					report_mismatch("result with no item waiting for it");
				end else begin
					want = pending_lines.pop_front();
					check_field("status", 64'(rsp_ch.status), 64'(want.status));
					check_field("source_line", 64'(rsp_ch.source_line), 64'(want.source_line));
					check_field("dest_line", 64'(rsp_ch.dest_line), 64'(want.dest_line));
					check_field("line_bytes", 64'(rsp_ch.line_bytes), 64'(want.line_bytes));
					check_field("last_line", 64'(rsp_ch.last_line), 64'(want.last_line));
				end
			end
		end
	end

	// Give up on a hung run.
	initial begin
		#1_500_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/apl_pkg.sv
rtl/core/apl_ifs.sv
rtl/core/apl_cell.sv
rtl/core/axis_permute_line_address_gen_core.sv
tb/tb.sv
